/* rtl/peti_pkg.sv */
// Shared types and constants of the peripheral event/task interconnect.
`timescale 1ns / 1ps
package peti_pkg;

    localparam int unsigned CHAN_MAX = 16;

    localparam logic [2:0] FUNC_BUS_WR = 3'd0;
    localparam logic [2:0] FUNC_BUS_RD = 3'd1;
    localparam logic [2:0] FUNC_TRIG   = 3'd2;
    localparam logic [2:0] FUNC_RUN    = 3'd3;
    localparam logic [2:0] FUNC_RESP   = 3'd4;

    localparam logic [2:0] KIND_ACK    = 3'd0;
    localparam logic [2:0] KIND_RDATA  = 3'd1;
    localparam logic [2:0] KIND_MREAD  = 3'd2;
    localparam logic [2:0] KIND_MWRITE = 3'd3;
    localparam logic [2:0] KIND_ERR    = 3'd4;

    localparam logic [11:0] OFF_EN_SET  = 12'h504;
    localparam logic [11:0] OFF_EN_CLR  = 12'h508;
    localparam logic [11:0] OFF_CH_LO   = 12'h510;
    localparam logic [11:0] OFF_CH_HI   = 12'h58C;
    localparam logic [11:0] OFF_GRP_LO  = 12'h800;
    localparam logic [11:0] OFF_GRP_1   = 12'h804;
    localparam logic [11:0] OFF_GRP_HI  = 12'h80C;

    typedef struct packed {
        logic [2:0]  func;
        logic [11:0] offset;
        logic [31:0] data;
        logic [3:0]  chan_index;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] mem_address;
        logic [31:0] out_data;
        logic [3:0]  out_channel;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic       bad;
        logic       en_set;
        logic       en_clr;
        logic       ch_wr;
        logic       ch_evt;
        logic [3:0] ch_id;
        logic       grp_wr;
        logic [1:0] grp_id;
        logic       rd_sel;
    } t_dec;

endpackage

/* rtl/peti_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module peti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/peti_dec.sv */
// Bus address decoder of the interconnect register page.
`timescale 1ns / 1ps
module peti_dec #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic [2:0]     i_func,
    input  logic [11:0]    i_offset,
    output peti_pkg::t_dec o_dec
);

    localparam logic [4:0] NCH = 5'(NUM_CHANNELS);

    logic [11:0] ch_diff;
    logic        in_ch;
    logic        in_grp;
    logic        is_set;
    logic        is_clr;
    logic        is_wr;
    logic        is_rd;
    logic        rd_hit;

    always_comb begin
        ch_diff = i_offset - peti_pkg::OFF_CH_LO;
        in_ch   = (i_offset >= peti_pkg::OFF_CH_LO) && (i_offset <= peti_pkg::OFF_CH_HI);
        in_grp  = (i_offset >= peti_pkg::OFF_GRP_LO) && (i_offset <= peti_pkg::OFF_GRP_HI);
        is_set  = (i_offset == peti_pkg::OFF_EN_SET);
        is_clr  = (i_offset == peti_pkg::OFF_EN_CLR);
        is_wr   = (i_func == peti_pkg::FUNC_BUS_WR);
        is_rd   = (i_func == peti_pkg::FUNC_BUS_RD);
        rd_hit  = (i_offset == peti_pkg::OFF_GRP_LO) || (i_offset == peti_pkg::OFF_GRP_1);

        o_dec        = '0;
        o_dec.ch_id  = ch_diff[6:3];
        o_dec.ch_evt = (i_offset[2:0] == 3'd0);
        o_dec.grp_id = i_offset[3:2];
        o_dec.rd_sel = (i_offset == peti_pkg::OFF_GRP_1);
        o_dec.en_set = is_wr && is_set;
        o_dec.en_clr = is_wr && is_clr;
        o_dec.ch_wr  = is_wr && in_ch && ({1'b0, ch_diff[6:3]} < NCH);
        o_dec.grp_wr = is_wr && in_grp;
        o_dec.bad    = (is_wr && !(is_set || is_clr || in_ch || in_grp))
                    || (is_rd && !rd_hit);
    end

endmodule

/* rtl/peripheral_event_task_interconnect_core.sv */
// Top level: register page, channel scan sequencer and result register.
//
//   channel   valid         ready         word
//   input     i_in_valid    o_in_ready    i_in_word  (func, offset, data, chan_index)
//   output    o_out_valid   i_out_ready   o_out_word (kind, mem_address, out_data,
//                                                     out_channel, last)
//
// Bus access and trigger write are handled in S_IDLE. Read response: via S_RESP
// (task address RAM read). Run tick: S_SCAN steps past each skipped channel and hands
// each issued read to S_EMIT, back to S_IDLE when no channel qualifies; one scan
// counter walks the event address RAM.
// Reset clears enable mask, group words, pending flag and the per-channel valid flags.
// A full result register that is not taken stalls the sequencer and the input.
`timescale 1ns / 1ps
module peripheral_event_task_interconnect_core #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  peti_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output peti_pkg::t_out_word  o_out_word
);

    localparam int         CH_AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [4:0] NCH       = 5'(NUM_CHANNELS);
    localparam logic [15:0] CHAN_BITS = (NUM_CHANNELS >= 16) ? 16'hFFFF
                                      : 16'((32'd1 << NUM_CHANNELS) - 32'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic                 r_ovld, n_ovld;
    peti_pkg::t_out_word  r_oword, n_oword;
    logic [15:0]          r_en, n_en;
    logic                 r_pend, n_pend;
    logic [31:0]          r_grp [4];
    logic [31:0]          n_grp [4];
    logic [15:0]          r_ev_nz, n_ev_nz;
    logic [15:0]          r_tk_nz, n_tk_nz;
    logic [15:0]          r_tk_vld, n_tk_vld;
    logic [3:0]           r_idx, n_idx;
    logic [3:0]           r_ci, n_ci;

    peti_pkg::t_dec       dec;
    logic                 acc;
    logic                 out_free;
    logic [15:0]          qual;
    logic [15:0]          rem_ge;
    logic [15:0]          rem_gt;
    logic [31:0]          ev_rdata;
    logic [31:0]          tk_rdata;
    logic [3:0]           tk_raddr;
    logic                 ev_we;
    logic                 tk_we;

    peti_dec #(.NUM_CHANNELS(NUM_CHANNELS)) u_dec (
        .i_func   (i_in_word.func),
        .i_offset (i_in_word.offset),
        .o_dec    (dec)
    );

    assign acc      = i_in_valid && o_in_ready;
    assign out_free = !r_ovld || i_out_ready;
    assign ev_we    = acc && dec.ch_wr && dec.ch_evt;
    assign tk_we    = acc && dec.ch_wr && !dec.ch_evt;
    assign tk_raddr = (r_state == S_IDLE) ? i_in_word.chan_index : r_ci;
    assign qual     = r_en & r_ev_nz & r_tk_nz;
    assign rem_ge   = qual & ~((16'd1 << r_idx) - 16'd1);
    assign rem_gt   = qual & ~((16'd2 << r_idx) - 16'd1);

    peti_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_ev_ram (
        .i_clk   (i_clk),
        .i_we    (ev_we),
        .i_waddr (dec.ch_id[CH_AW-1:0]),
        .i_wdata (i_in_word.data),
        .i_raddr (r_idx[CH_AW-1:0]),
        .o_rdata (ev_rdata)
    );

    peti_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_tk_ram (
        .i_clk   (i_clk),
        .i_we    (tk_we),
        .i_waddr (dec.ch_id[CH_AW-1:0]),
        .i_wdata (i_in_word.data),
        .i_raddr (tk_raddr[CH_AW-1:0]),
        .o_rdata (tk_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign o_out_valid = r_ovld;
    assign o_out_word  = r_oword;

    always_comb begin
        n_state  = r_state;
        n_ovld   = r_ovld;
        n_oword  = r_oword;
        n_en     = r_en;
        n_pend   = r_pend;
        n_grp    = r_grp;
        n_ev_nz  = r_ev_nz;
        n_tk_nz  = r_tk_nz;
        n_tk_vld = r_tk_vld;
        n_idx    = r_idx;
        n_ci     = r_ci;

        if (r_ovld && i_out_ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_in_word.func)
                        peti_pkg::FUNC_BUS_WR, peti_pkg::FUNC_BUS_RD: begin
                            n_ovld                = 1'b1;
                            n_oword               = '0;
                            n_oword.last          = 1'b1;
                            if (dec.bad) begin
                                n_oword.kind = peti_pkg::KIND_ERR;
                            end else if (i_in_word.func == peti_pkg::FUNC_BUS_RD) begin
                                n_oword.kind     = peti_pkg::KIND_RDATA;
                                n_oword.out_data = dec.rd_sel ? r_grp[1] : r_grp[0];
                            end else begin
                                n_oword.kind = peti_pkg::KIND_ACK;
                            end
                            if (dec.en_set) begin
                                n_en = (r_en | i_in_word.data[15:0]) & CHAN_BITS;
                            end
                            if (dec.en_clr) begin
                                n_en = (r_en & ~i_in_word.data[15:0]) & CHAN_BITS;
                            end
                            if (dec.grp_wr) begin
                                n_grp[dec.grp_id] = i_in_word.data;
                            end
                            if (dec.ch_wr && dec.ch_evt) begin
                                n_ev_nz[dec.ch_id] = (i_in_word.data != 32'd0);
                            end
                            if (dec.ch_wr && !dec.ch_evt) begin
                                n_tk_nz[dec.ch_id]  = (i_in_word.data != 32'd0);
                                n_tk_vld[dec.ch_id] = 1'b1;
                            end
                        end
                        peti_pkg::FUNC_TRIG: begin
                            n_pend = (i_in_word.data != 32'd0);
                        end
                        peti_pkg::FUNC_RUN: begin
                            if (r_pend) begin
                                n_pend  = 1'b0;
                                n_idx   = 4'd0;
                                n_state = S_SCAN;
                            end
                        end
                        peti_pkg::FUNC_RESP: begin
                            if ((i_in_word.data != 32'd0)
                                && ({1'b0, i_in_word.chan_index} < NCH)) begin
                                n_ci    = i_in_word.chan_index;
                                n_state = S_RESP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_ovld              = 1'b1;
                    n_oword.kind        = peti_pkg::KIND_MWRITE;
                    n_oword.mem_address = r_tk_vld[r_ci] ? tk_rdata : 32'd0;
                    n_oword.out_data    = 32'd1;
                    n_oword.out_channel = r_ci;
                    n_oword.last        = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            S_SCAN: begin
                if (rem_ge == 16'd0) begin
                    n_state = S_IDLE;
                end else if (qual[r_idx]) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovld              = 1'b1;
                    n_oword.kind        = peti_pkg::KIND_MREAD;
                    n_oword.mem_address = ev_rdata;
                    n_oword.out_data    = 32'd0;
                    n_oword.out_channel = r_idx;
                    n_oword.last        = (rem_gt == 16'd0);
                    if (rem_gt == 16'd0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 4'd1;
                        n_state = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovld   <= 1'b0;
            r_en     <= '0;
            r_pend   <= 1'b0;
            r_grp    <= '{default: '0};
            r_ev_nz  <= '0;
            r_tk_nz  <= '0;
            r_tk_vld <= '0;
        end else begin
            r_state  <= n_state;
            r_ovld   <= n_ovld;
            r_en     <= n_en;
            r_pend   <= n_pend;
            r_grp    <= n_grp;
            r_ev_nz  <= n_ev_nz;
            r_tk_nz  <= n_tk_nz;
            r_tk_vld <= n_tk_vld;
        end
        r_oword <= n_oword;
        r_idx   <= n_idx;
        r_ci    <= n_ci;
    end

    a_mwrite_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && (r_oword.kind == peti_pkg::KIND_MWRITE)) |-> r_oword.last)
        else $error("task write result not marked last");

    a_mread_qual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> qual[r_idx])
        else $error("scan emits a channel that does not qualify");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_in_word.func == peti_pkg::FUNC_RUN)) |=> !r_pend)
        else $error("run tick left pending flag set");

    a_en_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_en & ~CHAN_BITS) == 16'd0))
        else $error("enable bit set beyond channel count");

endmodule
